[sv/itce_pkg.sv]
`default_nettype none

package itce_pkg;

    localparam int unsigned SumWidth = 17;
    localparam logic [15:0] SegmentLimitReset = 16'd1480;
    localparam logic [15:0] PositionMax = 16'hffff;
    localparam logic [15:0] IpCsumOfsHi = 16'd10;
    localparam logic [15:0] IpCsumOfsLo = 16'd11;
    localparam logic [15:0] ProtocolPos = 16'd9;
    localparam logic [15:0] AddrFirstPos = 16'd12;
    localparam logic [15:0] AddrLastPos = 16'd19;
    localparam logic [15:0] TotalHiPos = 16'd2;
    localparam logic [15:0] TotalLoPos = 16'd3;
    localparam logic [15:0] EarlyBytes = 16'd4;
    localparam logic [15:0] TcpCsumOfs = 16'd16;

    typedef logic [SumWidth-1:0] t_sum;

    typedef struct packed {
        logic [15:0] ip_checksum;
        logic [15:0] tcp_checksum;
        logic        malformed;
    } t_result;

    // one's-complement add with end-around carry
    function automatic t_sum oc_add(input t_sum acc, input logic [15:0] word);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, acc[15:0]} + {1'b0, word};
        f = {1'b0, s[15:0]} + {16'd0, s[16]};
        return f;
    endfunction

endpackage

`default_nettype wire

[sv/itce_byte_if.sv]
`default_nettype none

interface itce_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[sv/itce_result_if.sv]
`default_nettype none

interface itce_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] ip_checksum;
    logic [15:0] tcp_checksum;
    logic        malformed;

    modport source (output valid, output ip_checksum, output tcp_checksum,
                    output malformed, input ready);
    modport sink (input valid, input ip_checksum, input tcp_checksum,
                  input malformed, output ready);
endinterface

`default_nettype wire

[sv/ipv4_tcp_checksum_engine_top.sv]
// IPv4 header and TCP checksum engine.
// i_pkt carries the packet one byte per transfer in network order; last_byte
// marks the final byte. o_res carries one result per packet: the IP header
// checksum, the TCP checksum over pseudo-header and segment, and a malformed
// flag (short packet, or total length below header length).
// i_cfg_wr_en / i_cfg_wr_data write segment_limit, the most segment bytes
// summed (reset value 1480); write it only between packets.
// Throughput: one byte per cycle while i_pkt.ready is high. Each byte adds
// into the running sums in the cycle it is taken; the result is registered and
// appears on o_res the cycle after the final byte if o_res is empty or ready.
// A two-entry output (result register plus skid register) lets the engine
// keep taking bytes while a result waits; i_pkt.ready drops only when both
// entries hold results, and the results are kept in order.
// Reset (synchronous, active low) clears the running state and both output
// entries and restores segment_limit to 1480.
`default_nettype none

module ipv4_tcp_checksum_engine_top
    import itce_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [15:0] i_cfg_wr_data,
    itce_byte_if.sink     i_pkt,
    itce_result_if.source o_res
);

    logic [15:0] r_seg_limit;
    logic [15:0] r_pos,   n_pos;
    logic [5:0]  r_hdr,   n_hdr;
    logic [15:0] r_total, n_total;
    t_sum        r_hsum,  n_hsum;
    t_sum        r_ssum,  n_ssum;

    logic        r_out_valid, n_out_valid;
    logic        r_skid_valid, n_skid_valid;
    t_result     r_out, n_out;
    t_result     r_skid, n_skid;

    logic        accept;
    logic        out_fire;
    logic [15:0] word;
    logic [15:0] ofs;
    logic [15:0] hdr16;
    logic [15:0] len_term;
    logic [16:0] count;
    t_sum        ssum_a;
    t_sum        ssum_b;
    t_sum        tsum;
    logic        in_hdr;
    logic        in_pseudo;
    logic        in_seg;
    t_result     res;

    assign i_pkt.ready = !r_skid_valid;
    assign accept      = i_pkt.valid && !r_skid_valid;
    assign out_fire    = r_out_valid && o_res.ready;

    always_comb begin
        word = r_pos[0] ? {8'd0, i_pkt.data_byte} : {i_pkt.data_byte, 8'd0};

        n_hdr   = r_hdr;
        n_total = r_total;
        if (r_pos == 16'd0) begin
            n_hdr = {i_pkt.data_byte[3:0], 2'b00};
        end else if (r_pos == TotalHiPos) begin
            n_total = {i_pkt.data_byte, r_total[7:0]};
        end else if (r_pos == TotalLoPos) begin
            n_total = {r_total[15:8], i_pkt.data_byte};
        end
        hdr16 = {10'd0, n_hdr};

        in_hdr = (r_pos < hdr16) && (r_pos != IpCsumOfsHi) && (r_pos != IpCsumOfsLo);
        n_hsum = in_hdr ? oc_add(r_hsum, word) : r_hsum;

        in_pseudo = (r_pos == ProtocolPos) ||
                    ((r_pos >= AddrFirstPos) && (r_pos <= AddrLastPos));
        ssum_a = in_pseudo ? oc_add(r_ssum, word) : r_ssum;

        ofs    = r_pos - hdr16;
        in_seg = (r_pos >= hdr16) && ((r_pos < EarlyBytes) || (r_pos < n_total)) &&
                 (ofs < r_seg_limit) && (ofs != TcpCsumOfs) &&
                 (ofs != TcpCsumOfs + 16'd1);
        ssum_b = in_seg ? oc_add(ssum_a, word) : ssum_a;
        n_ssum = ssum_b;

        n_pos = (r_pos < PositionMax) ? r_pos + 16'd1 : r_pos;

        count    = {1'b0, r_pos} + 17'd1;
        len_term = n_total - hdr16;
        tsum     = oc_add(ssum_b, len_term);
        res.ip_checksum  = ~n_hsum[15:0];
        res.tcp_checksum = ~tsum[15:0];
        res.malformed    = (count < {1'b0, n_total}) || (n_total < hdr16);

        if (i_pkt.last_byte) begin
            n_pos   = 16'd0;
            n_hdr   = 6'd0;
            n_total = 16'd0;
            n_hsum  = '0;
            n_ssum  = '0;
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (out_fire) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (accept && i_pkt.last_byte) begin
            if (!r_out_valid || out_fire) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end else if (out_fire) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_limit  <= SegmentLimitReset;
            r_pos        <= 16'd0;
            r_hdr        <= 6'd0;
            r_total      <= 16'd0;
            r_hsum       <= '0;
            r_ssum       <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_seg_limit <= i_cfg_wr_data;
            end
            if (accept) begin
                r_pos   <= n_pos;
                r_hdr   <= n_hdr;
                r_total <= n_total;
                r_hsum  <= n_hsum;
                r_ssum  <= n_ssum;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.ip_checksum  = r_out.ip_checksum;
    assign o_res.tcp_checksum = r_out.tcp_checksum;
    assign o_res.malformed    = r_out.malformed;

endmodule

`default_nettype wire
